// ----- design/rfcd_pkg.sv -----
package rfcd_pkg;

    // Default width of the two millisecond timers.
    localparam int TIMER_BITS_DEFAULT = 16;

    // Field widths.
    localparam int LEN_W       = 6;
    localparam int BYTE_W      = 8;
    localparam int CFG_W       = 16;
    localparam int DRIVE_W     = 14;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_TUSER_W = 2;

    // Minimum message length that is looked at.
    localparam logic [LEN_W-1:0] MIN_MSG_LEN = LEN_W'(2);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_AUTH_KEY        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD    = 2'd2;

    // Configuration reset values.
    localparam logic [BYTE_W-1:0] AUTH_KEY_RESET        = 8'd100;
    localparam logic [CFG_W-1:0]  RELEASE_TIMEOUT_RESET = 16'd200;
    localparam logic [CFG_W-1:0]  FRAME_PERIOD_RESET    = 16'd50;

    // Input word kinds.
    localparam logic CMD_MESSAGE = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    // Button codes.
    localparam logic [BYTE_W-1:0] CODE_RELEASED  = 8'd0;
    localparam logic [BYTE_W-1:0] CODE_AUTO_ON   = 8'd72;
    localparam logic [BYTE_W-1:0] CODE_AUTO_OFF  = 8'd80;
    localparam logic [BYTE_W-1:0] CODE_DEPOT     = 8'd70;
    localparam logic [BYTE_W-1:0] CODE_OUT4      = 8'd76;
    localparam logic [BYTE_W-1:0] CODE_OUT3      = 8'd75;
    localparam logic [BYTE_W-1:0] CODE_OUT11     = 8'd79;
    localparam logic [BYTE_W-1:0] CODE_OUT10     = 8'd71;
    localparam logic [BYTE_W-1:0] CODE_OUT1      = 8'd78;
    localparam logic [BYTE_W-1:0] CODE_OUT2      = 8'd74;
    localparam logic [BYTE_W-1:0] CODE_OUT12     = 8'd69;
    localparam logic [BYTE_W-1:0] CODE_OUT13     = 8'd73;
    localparam logic [BYTE_W-1:0] CODE_OUT5      = 8'd77;
    localparam logic [BYTE_W-1:0] PREV_CODE_RESET = 8'd255;

    // Position of each output bit inside the drive vector.
    // Output bits 1..7 sit at 0..6, output bits 9..15 at 7..13.
    localparam int DRV_OUT1  = 0;
    localparam int DRV_OUT2  = 1;
    localparam int DRV_OUT3  = 2;
    localparam int DRV_OUT4  = 3;
    localparam int DRV_OUT5  = 4;
    localparam int DRV_OUT6  = 5;
    localparam int DRV_OUT7  = 6;
    localparam int DRV_OUT9  = 7;
    localparam int DRV_OUT10 = 8;
    localparam int DRV_OUT11 = 9;
    localparam int DRV_OUT12 = 10;
    localparam int DRV_OUT13 = 11;
    localparam int DRV_OUT14 = 12;
    localparam int DRV_OUT15 = 13;

    typedef struct packed {
        logic              command;
        logic [LEN_W-1:0]  message_length;
        logic [BYTE_W-1:0] key_byte;
        logic [BYTE_W-1:0] code_byte;
    } item_t;

    typedef struct packed {
        logic              frame_valid;
        logic [BYTE_W-1:0] frame_byte;
        logic              frame_second;
        logic              indicator_led;
    } result_t;

    // Button and frame state, without the timers.
    typedef struct packed {
        logic [BYTE_W-1:0]  previous_code;
        logic               press_latched;
        logic               auto_mode;
        logic               depot_open;
        logic [DRIVE_W-1:0] drive_bits;
        logic               frame_phase;
        logic               led_state;
    } ctrl_t;

    localparam ctrl_t CTRL_RESET = '{
        previous_code: PREV_CODE_RESET,
        press_latched: 1'b0,
        auto_mode:     1'b0,
        depot_open:    1'b0,
        drive_bits:    '0,
        frame_phase:   1'b0,
        led_state:     1'b0
    };

endpackage

// ----- design/rfcd_step.sv -----
module rfcd_step
    import rfcd_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEFAULT
)
(
    input  item_t                  item,
    input  ctrl_t                  ctrl_cur,
    input  logic [TIMER_BITS-1:0]  release_timer_cur,
    input  logic [TIMER_BITS-1:0]  frame_timer_cur,
    input  logic [BYTE_W-1:0]      auth_key,
    input  logic [CFG_W-1:0]       release_timeout_ms,
    input  logic [CFG_W-1:0]       frame_period_ms,
    output ctrl_t                  ctrl_new,
    output logic [TIMER_BITS-1:0]  release_timer_new,
    output logic [TIMER_BITS-1:0]  frame_timer_new,
    output result_t                result
);

    localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    // Applies one button code to the state, as a press or as a release.
    function automatic ctrl_t decode_code(ctrl_t s, logic [BYTE_W-1:0] code);
        ctrl_t r;
        r = s;
        if (code == CODE_RELEASED) begin
            r.drive_bits    = '0;
            r.press_latched = 1'b0;
            if (s.auto_mode) begin
                r.drive_bits[DRV_OUT9] = 1'b1;
            end
        end else if (!s.press_latched) begin
            unique case (code)
                CODE_AUTO_ON:  r.auto_mode = 1'b1;
                CODE_AUTO_OFF: r.auto_mode = 1'b0;
                CODE_DEPOT:
                begin
                    if (s.depot_open) begin
                        r.drive_bits[DRV_OUT7]  = 1'b1;
                        r.drive_bits[DRV_OUT15] = 1'b1;
                        r.depot_open            = 1'b0;
                    end else begin
                        r.drive_bits[DRV_OUT6]  = 1'b1;
                        r.drive_bits[DRV_OUT14] = 1'b1;
                        r.depot_open            = 1'b1;
                    end
                end
                CODE_OUT4:  r.drive_bits[DRV_OUT4]  = 1'b1;
                CODE_OUT3:  r.drive_bits[DRV_OUT3]  = 1'b1;
                CODE_OUT11: r.drive_bits[DRV_OUT11] = 1'b1;
                CODE_OUT10: r.drive_bits[DRV_OUT10] = 1'b1;
                CODE_OUT1:  r.drive_bits[DRV_OUT1]  = 1'b1;
                CODE_OUT2:  r.drive_bits[DRV_OUT2]  = 1'b1;
                CODE_OUT12: r.drive_bits[DRV_OUT12] = 1'b1;
                CODE_OUT13: r.drive_bits[DRV_OUT13] = 1'b1;
                CODE_OUT5:  r.drive_bits[DRV_OUT5]  = 1'b1;
                default:    r = s;
            endcase
            r.press_latched = 1'b1;
        end
        return r;
    endfunction

    logic [TIMER_BITS-1:0] release_inc;
    logic [TIMER_BITS-1:0] frame_inc;
    logic                  release_due;
    logic                  frame_due;
    logic                  msg_ok;

    assign release_inc = (release_timer_cur == TIMER_MAX) ? release_timer_cur
                                                          : release_timer_cur + 1'b1;
    assign frame_inc   = (frame_timer_cur == TIMER_MAX) ? frame_timer_cur
                                                        : frame_timer_cur + 1'b1;
    assign release_due = CMP_W'(release_inc) >= CMP_W'(release_timeout_ms);
    assign frame_due   = CMP_W'(frame_inc) >= CMP_W'(frame_period_ms);
    assign msg_ok      = (item.message_length >= MIN_MSG_LEN) && (item.key_byte == auth_key);

    always_comb
    begin
        ctrl_new          = ctrl_cur;
        release_timer_new = release_timer_cur;
        frame_timer_new   = frame_timer_cur;
        result            = '0;

        if (item.command == CMD_MESSAGE) begin
            if (msg_ok) begin
                ctrl_new.led_state = 1'b1;
                release_timer_new  = '0;
                if (item.code_byte != ctrl_cur.previous_code) begin
                    ctrl_new = decode_code(ctrl_new, item.code_byte);
                    ctrl_new.previous_code = item.code_byte;
                end
                if (item.code_byte == CODE_RELEASED) begin
                    ctrl_new.led_state = 1'b0;
                end
            end
        end else begin
            release_timer_new = release_inc;
            frame_timer_new   = frame_inc;

            if (release_due) begin
                if ((ctrl_cur.previous_code != CODE_RELEASED) || ctrl_cur.press_latched) begin
                    ctrl_new = decode_code(ctrl_new, CODE_RELEASED);
                    ctrl_new.previous_code = CODE_RELEASED;
                    ctrl_new.led_state     = 1'b0;
                end
                release_timer_new = '0;
            end

            if (frame_due) begin
                frame_timer_new      = '0;
                ctrl_new.frame_phase = !ctrl_cur.frame_phase;
                result.frame_valid   = 1'b1;
                if (ctrl_new.frame_phase) begin
                    result.frame_byte   = {ctrl_new.drive_bits[DRV_OUT7:DRV_OUT1], 1'b1};
                    result.frame_second = 1'b0;
                end else begin
                    result.frame_byte   = {ctrl_new.drive_bits[DRV_OUT15:DRV_OUT9], 1'b0};
                    result.frame_second = 1'b1;
                end
            end
        end

        result.indicator_led = ctrl_new.led_state;
    end

endmodule

// ----- design/rf_remote_command_decoder_core.sv -----
// Remote command decoder. Each input word is either a received radio message
// (tuser = 0) or a one-millisecond tick (tuser = 1), and every input word
// yields exactly one output word. A message of two or more bytes whose key
// byte equals the auth_key register lights the indicator (code zero clears
// it), restarts the release timer and, when its button code differs from
// the previous code, is decoded: code zero releases all buttons and keeps
// the automatic bit, while a nonzero code acts once per press (drive
// bits, depot open/close toggle, automatic mode on/off). A tick advances
// two saturating timers of TIMER_BITS bits; the release timer forces one
// release when no valid message has arrived for release_timeout_ms ticks,
// and the frame timer emits one frame byte every frame_period_ms ticks,
// first and second frame in turn. Ticks without a frame give an output
// word with frame_valid, frame_byte and frame_second at zero. The block
// takes one word per clock cycle while its output is read; a word is held
// in an input register and its result is then registered in the output
// register. The only loop is the button and timer state, which is updated
// once for each word. Configuration writes are always taken (cfg_ready is
// tied high) and must only be issued while no word is in flight.
module rf_remote_command_decoder_core
    import rfcd_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // Bits from the lowest up: message_length[5:0], key_byte[7:0],
    // code_byte[7:0], two zero bits.
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // Bit 0: command (0 message, 1 tick).
    input  logic                   s_axis_tuser,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // Bits from the lowest up: frame_byte[7:0], indicator_led, seven zero bits.
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // Bits from the lowest up: frame_valid, frame_second.
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    // Input stage.
    logic    in_valid_reg;
    logic    in_valid_next;
    item_t   in_item_reg;
    logic    in_accept;
    logic    advance;

    // Output stage.
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_result_reg;

    // Decoder state.
    ctrl_t                 ctrl_reg;
    logic [TIMER_BITS-1:0] release_timer_reg;
    logic [TIMER_BITS-1:0] frame_timer_reg;

    // Configuration registers.
    logic [BYTE_W-1:0] auth_key_reg;
    logic [CFG_W-1:0]  release_timeout_reg;
    logic [CFG_W-1:0]  frame_period_reg;

    // Step results.
    ctrl_t                 ctrl_next;
    logic [TIMER_BITS-1:0] release_timer_next;
    logic [TIMER_BITS-1:0] frame_timer_next;
    result_t               result_next;

    // The word in the input register moves on when the output register is
    // empty or is being read in this cycle.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    always_comb
    begin
        if (in_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    rfcd_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .item               (in_item_reg),
        .ctrl_cur           (ctrl_reg),
        .release_timer_cur  (release_timer_reg),
        .frame_timer_cur    (frame_timer_reg),
        .auth_key           (auth_key_reg),
        .release_timeout_ms (release_timeout_reg),
        .frame_period_ms    (frame_period_reg),
        .ctrl_new           (ctrl_next),
        .release_timer_new  (release_timer_next),
        .frame_timer_new    (frame_timer_next),
        .result             (result_next)
    );

    // Control state, decoder state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            ctrl_reg            <= CTRL_RESET;
            release_timer_reg   <= '0;
            frame_timer_reg     <= '0;
            auth_key_reg        <= AUTH_KEY_RESET;
            release_timeout_reg <= RELEASE_TIMEOUT_RESET;
            frame_period_reg    <= FRAME_PERIOD_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;

            if (advance) begin
                ctrl_reg          <= ctrl_next;
                release_timer_reg <= release_timer_next;
                frame_timer_reg   <= frame_timer_next;
            end

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_AUTH_KEY:        auth_key_reg        <= cfg_data[BYTE_W-1:0];
                    REG_RELEASE_TIMEOUT: release_timeout_reg <= cfg_data;
                    REG_FRAME_PERIOD:    frame_period_reg    <= cfg_data;
                    default:             ;
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept) begin
            in_item_reg.command        <= s_axis_tuser;
            in_item_reg.message_length <= s_axis_tdata[LEN_W-1:0];
            in_item_reg.key_byte       <= s_axis_tdata[LEN_W +: BYTE_W];
            in_item_reg.code_byte      <= s_axis_tdata[LEN_W+BYTE_W +: BYTE_W];
        end
        if (advance) begin
            out_result_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-BYTE_W-1){1'b0}},
                            out_result_reg.indicator_led,
                            out_result_reg.frame_byte};
    assign m_axis_tuser  = {out_result_reg.frame_second, out_result_reg.frame_valid};

endmodule

// ----- design/rfcd_checker.sv -----
module rfcd_checker
    import rfcd_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    // A word without a frame carries no frame bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |->
            (m_axis_tdata[BYTE_W-1:0] == '0) && !m_axis_tuser[1])
        else $error("frame bits set on a word without a frame");

    // The first frame has its marker bit set, the second has it clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[0] == !m_axis_tuser[1]))
        else $error("frame marker bit does not match the frame kind");

    // An empty output register never holds back the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while the output is empty");

    // A stalled output word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled output word changed");

endmodule

bind rf_remote_command_decoder_core rfcd_checker u_rfcd_checker (.*);
